### rtl/csi_rpu_pkg.sv
package csi_rpu_pkg;

   // Pixel packing codes
   localparam logic [1:0] FMT_RAW8  = 2'd0;
   localparam logic [1:0] FMT_RAW10 = 2'd1;
   localparam logic [1:0] FMT_RAW12 = 2'd2;
   localparam logic [1:0] FMT_RSVD  = 2'd3;

   // Register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_PACK_FMT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_STRIDE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
   localparam int unsigned CSR_DATA_W = 16;

   // Defaults for the top level parameters
   localparam int unsigned MAX_LINE_BYTES_DEF = 16384;
   localparam int unsigned MAX_ROWS_DEF       = 8192;

   // Fixed limits and widths
   localparam logic [13:0] MAX_WIDTH = 14'd8192;
   localparam int unsigned CFG_LEN_W = 17;   // holds any saturated stride or height
   localparam int unsigned COL_W     = 18;   // column counter, room for format changes
   localparam int unsigned QUEUE_DEPTH = 4;

   // Reciprocals for the division of the stride by 5 and by 3
   localparam logic [15:0] RECIP5 = 16'd52429;
   localparam int unsigned SHIFT5 = 18;
   localparam logic [15:0] RECIP3 = 16'd43691;
   localparam int unsigned SHIFT3 = 17;

   // Derived configuration, as seen by the front end
   typedef struct packed {
      logic [1:0]           fmt;
      logic [15:0]          start_offset;
      logic [CFG_LEN_W-1:0] stride;      // zero mapped to one, saturated
      logic [CFG_LEN_W-1:0] height;      // saturated
      logic [CFG_LEN_W-1:0] pix_bytes;   // bytes of whole groups per row
      logic [13:0]          last_col;    // pixels per row actually output
   } cfg_type;

   // One complete pixel group, queued from front to back
   typedef struct packed {
      logic [3:0][7:0] gbytes;
      logic [7:0]      last_byte;
      logic [1:0]      fmt;
      logic [12:0]     col;
      logic [12:0]     row;
      logic            frame_last;
   } group_type;

   // Pixels per group
   function automatic logic [2:0] fmt_ppg(input logic [1:0] fmt);
      logic [2:0] r;
      unique case (fmt)
         FMT_RAW8:  r = 3'd1;
         FMT_RAW10: r = 3'd4;
         FMT_RAW12: r = 3'd2;
         default:   r = 3'd0;
      endcase
      return r;
   endfunction

   // Bytes per group
   function automatic logic [2:0] fmt_bpg(input logic [1:0] fmt);
      logic [2:0] r;
      unique case (fmt)
         FMT_RAW8:  r = 3'd1;
         FMT_RAW10: r = 3'd5;
         FMT_RAW12: r = 3'd3;
         default:   r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/csi_rpu_csr.sv
module csi_rpu_csr #(
   parameter int unsigned MAX_LINE_BYTES = csi_rpu_pkg::MAX_LINE_BYTES_DEF,
   parameter int unsigned MAX_ROWS       = csi_rpu_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [csi_rpu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csi_rpu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output csi_rpu_pkg::cfg_type                cfg
);
   import csi_rpu_pkg::*;

   logic [1:0]  fmt_ff, fmt_in;
   logic [15:0] start_ff, start_in;
   logic [14:0] stride_ff, stride_in;
   logic [13:0] width_ff, width_in;
   logic [13:0] height_ff, height_in;
   cfg_type     cfg_ff, cfg_in;

   logic [14:0] stride_nz;
   logic [13:0] width_sat;
   logic [14:0] s15;
   logic [30:0] prod5, prod3;
   logic [14:0] q5, q3, wq, sq, groups_w;
   logic [13:0] groups;

   // Register writes
   always_comb begin
      fmt_in    = fmt_ff;
      start_in  = start_ff;
      stride_in = stride_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_PACK_FMT:     fmt_in    = csr_wdata[1:0];
            REG_START_OFFSET: start_in  = csr_wdata;
            REG_LINE_STRIDE:  stride_in = csr_wdata[14:0];
            REG_FRAME_WIDTH:  width_in  = csr_wdata[13:0];
            REG_FRAME_HEIGHT: height_in = csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // Derived values, registered together with the raw registers
   always_comb begin
      stride_nz = (stride_in == 15'd0) ? 15'd1 : stride_in;
      cfg_in.fmt          = fmt_in;
      cfg_in.start_offset = start_in;
      cfg_in.stride = (32'(stride_nz) > MAX_LINE_BYTES) ? CFG_LEN_W'(MAX_LINE_BYTES)
                                                        : CFG_LEN_W'(stride_nz);
      cfg_in.height = (32'(height_in) > MAX_ROWS) ? CFG_LEN_W'(MAX_ROWS)
                                                  : CFG_LEN_W'(height_in);
      width_sat = (width_in > MAX_WIDTH) ? MAX_WIDTH : width_in;

      // saturated stride never exceeds the 15-bit register range
      s15   = 15'(cfg_in.stride);
      prod5 = 31'(s15) * 31'(RECIP5);
      prod3 = 31'(s15) * 31'(RECIP3);
      q5    = 15'(prod5 >> SHIFT5);
      q3    = 15'(prod3 >> SHIFT3);

      unique case (fmt_in)
         FMT_RAW10: begin
            wq = 15'(width_sat >> 2);
            sq = q5;
         end
         FMT_RAW12: begin
            wq = 15'(width_sat >> 1);
            sq = q3;
         end
         default: begin
            wq = 15'(width_sat);
            sq = s15;
         end
      endcase
      groups_w = (sq < wq) ? sq : wq;
      groups   = 14'(groups_w);

      unique case (fmt_in)
         FMT_RAW8: begin
            cfg_in.pix_bytes = CFG_LEN_W'(groups);
            cfg_in.last_col  = groups;
         end
         FMT_RAW10: begin
            cfg_in.pix_bytes = (CFG_LEN_W'(groups) << 2) + CFG_LEN_W'(groups);
            cfg_in.last_col  = 14'(groups << 2);
         end
         FMT_RAW12: begin
            cfg_in.pix_bytes = (CFG_LEN_W'(groups) << 1) + CFG_LEN_W'(groups);
            cfg_in.last_col  = 14'(groups << 1);
         end
         default: begin
            cfg_in.pix_bytes = '0;
            cfg_in.last_col  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_RAW8;
         start_ff  <= 16'd0;
         stride_ff <= 15'd1;
         width_ff  <= 14'd1;
         height_ff <= 14'd1;
         cfg_ff.fmt          <= FMT_RAW8;
         cfg_ff.start_offset <= 16'd0;
         cfg_ff.stride       <= CFG_LEN_W'(1);
         cfg_ff.height       <= CFG_LEN_W'(1);
         cfg_ff.pix_bytes    <= CFG_LEN_W'(1);
         cfg_ff.last_col     <= 14'd1;
      end else begin
         fmt_ff    <= fmt_in;
         start_ff  <= start_in;
         stride_ff <= stride_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         cfg_ff    <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/csi_rpu_front.sv
module csi_rpu_front #(
   parameter int unsigned LINE_POS_W = 14,
   parameter int unsigned ROW_W      = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  csi_rpu_pkg::cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_frame_begin,
   input  logic                   q_full,
   output logic                   q_push,
   output csi_rpu_pkg::group_type q_entry
);
   import csi_rpu_pkg::*;

   logic [15:0]           skip_ff, skip_in, skip_e;
   logic [LINE_POS_W-1:0] pos_ff, pos_in, pos_e;
   logic [LINE_POS_W:0]   pos_inc;
   logic [ROW_W-1:0]      row_ff, row_in, row_e;
   logic [COL_W-1:0]      col_ff, col_in, col_e;
   logic [2:0]            gidx_ff, gidx_in, gidx_e;
   logic [3:0][7:0]       gbytes_ff, gbytes_in;
   logic [2:0]            ppg, bpg;
   logic                  accept, emit, fl;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign ppg       = fmt_ppg(cfg.fmt);
   assign bpg       = fmt_bpg(cfg.fmt);

   // Byte classification: skip, drop, collect or complete a group
   always_comb begin
      // frame start restarts every counter with this byte
      if (req_frame_begin) begin
         skip_e = '0;
         pos_e  = '0;
         row_e  = '0;
         col_e  = '0;
         gidx_e = '0;
      end else begin
         skip_e = skip_ff;
         pos_e  = pos_ff;
         row_e  = row_ff;
         col_e  = col_ff;
         gidx_e = gidx_ff;
      end
      skip_in   = skip_ff;
      pos_in    = pos_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      gidx_in   = gidx_ff;
      gbytes_in = gbytes_ff;
      emit      = 1'b0;
      pos_inc   = (LINE_POS_W+1)'(pos_e) + 1'b1;
      fl = (32'(row_e) + 32'd1 == 32'(cfg.height)) &&
           (32'(col_e) + 32'(ppg) == 32'(cfg.last_col));

      if (accept) begin
         skip_in = skip_e;
         pos_in  = pos_e;
         row_in  = row_e;
         col_in  = col_e;
         gidx_in = gidx_e;
         if (skip_e < cfg.start_offset) begin
            skip_in = skip_e + 16'd1;
         end else if (32'(row_e) < 32'(cfg.height)) begin
            if (32'(pos_e) < 32'(cfg.pix_bytes)) begin
               if (32'(gidx_e) + 32'd1 < 32'(bpg)) begin
                  gbytes_in[gidx_e[1:0]] = req_data_byte;
                  gidx_in = gidx_e + 3'd1;
               end else begin
                  emit    = 1'b1;
                  col_in  = col_e + COL_W'(ppg);
                  gidx_in = '0;
               end
            end
            // end of a received line
            if (32'(pos_inc) >= 32'(cfg.stride)) begin
               pos_in  = '0;
               row_in  = row_e + 1'b1;
               col_in  = '0;
               gidx_in = '0;
            end else begin
               pos_in = LINE_POS_W'(pos_inc);
            end
         end
      end
   end

   // Completed group toward the back end
   assign q_push = accept && emit;
   always_comb begin
      q_entry.gbytes     = gbytes_ff;
      q_entry.last_byte  = req_data_byte;
      q_entry.fmt        = cfg.fmt;
      q_entry.col        = 13'(col_e);
      q_entry.row        = 13'(row_e);
      q_entry.frame_last = fl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff   <= '0;
         pos_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         gidx_ff   <= '0;
         gbytes_ff <= '0;
      end else begin
         skip_ff   <= skip_in;
         pos_ff    <= pos_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         gidx_ff   <= gidx_in;
         gbytes_ff <= gbytes_in;
      end
   end

endmodule

### rtl/csi_rpu_queue.sv
module csi_rpu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  csi_rpu_pkg::group_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output csi_rpu_pkg::group_type head
);
   import csi_rpu_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   group_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/csi_rpu_back.sv
module csi_rpu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  csi_rpu_pkg::group_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_pixel_value,
   output logic [12:0]            rsp_pixel_column,
   output logic [12:0]            rsp_pixel_row,
   output logic                   rsp_run_last,
   output logic                   rsp_frame_last
);
   import csi_rpu_pkg::*;

   logic [1:0]  n_ff, n_in;
   logic        valid_ff, valid_in;
   logic [15:0] value_ff, value_in;
   logic [12:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic        run_last_ff, run_last_in;
   logic        frame_last_ff, frame_last_in;
   logic        load, last;
   logic [7:0]  b;

   // Output slot is free or drains this cycle
   assign load  = q_valid && (!valid_ff || rsp_ready);
   assign last  = (3'(n_ff) + 3'd1 == fmt_ppg(q_head.fmt));
   assign q_pop = load && last;
   assign b     = q_head.last_byte;

   // Pixel n of the head group
   always_comb begin
      unique case (q_head.fmt)
         FMT_RAW10: begin
            unique case (n_ff)
               2'd0:    value_in = {q_head.gbytes[0], b[1:0], 6'd0};
               2'd1:    value_in = {q_head.gbytes[1], b[3:2], 6'd0};
               2'd2:    value_in = {q_head.gbytes[2], b[5:4], 6'd0};
               default: value_in = {q_head.gbytes[3], b[7:6], 6'd0};
            endcase
         end
         FMT_RAW12: begin
            value_in = n_ff[0] ? {q_head.gbytes[1], b[7:4], 4'd0}
                               : {q_head.gbytes[0], b[3:0], 4'd0};
         end
         default: value_in = {b, 8'd0};
      endcase
      col_in        = q_head.col + 13'(n_ff);
      row_in        = q_head.row;
      run_last_in   = last;
      frame_last_in = last && q_head.frame_last;
   end

   always_comb begin
      n_in = n_ff;
      if (load) begin
         n_in = last ? 2'd0 : n_ff + 2'd1;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         n_ff     <= n_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff      <= value_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         run_last_ff   <= run_last_in;
         frame_last_ff <= frame_last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_value  = value_ff;
   assign rsp_pixel_column = col_ff;
   assign rsp_pixel_row    = row_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_frame_last   = frame_last_ff;

endmodule

### rtl/csi_raw_pixel_unpacker_core.sv
// Packed RAW pixel unpacker (RAW8, RAW10, RAW12).
// The req channel takes one byte of the frame per item, with req_frame_begin
// set on the first byte of a frame. The rsp channel gives one unpacked pixel
// per item, MSB-aligned in 16 bits, with its column and row; rsp_run_last
// marks the last pixel of a group, rsp_frame_last the final pixel.
// The csr port writes the packing format, start_offset, line_stride,
// frame_width and frame_height (indexes 0 to 4); write it only while idle.
// Throughput: one byte accepted per cycle while the queue is not full, one
// pixel delivered per cycle while rsp_ready is high, set by the single output
// register of the back end. RAW10 gives four pixels per five bytes, RAW12 two
// per three, so the output keeps up on average. A group passes the queue and
// the output register; its pixels follow one per cycle while rsp_ready holds.
// A four-entry group queue sits between byte classification and pixel output.
// When the receiver stalls, the queue fills and req_ready drops while it is
// full; no item is lost. Reset restores the register defaults, empties the
// queue and clears the counters, so the next byte acts as a frame start.
module csi_raw_pixel_unpacker_core #(
   parameter int unsigned MAX_LINE_BYTES = csi_rpu_pkg::MAX_LINE_BYTES_DEF,
   parameter int unsigned MAX_ROWS       = csi_rpu_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_frame_begin,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_pixel_value,
   output logic [12:0]                         rsp_pixel_column,
   output logic [12:0]                         rsp_pixel_row,
   output logic                                rsp_run_last,
   output logic                                rsp_frame_last,
   input  logic                                csr_wr_en,
   input  logic [csi_rpu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csi_rpu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import csi_rpu_pkg::*;

   localparam int unsigned LINE_POS_W = $clog2(MAX_LINE_BYTES);
   localparam int unsigned ROW_W      = $clog2(MAX_ROWS + 1);

   cfg_type   cfg;
   group_type q_entry, q_head;
   logic      q_push, q_full, q_pop, q_valid;

   csi_rpu_csr #(
      .MAX_LINE_BYTES(MAX_LINE_BYTES),
      .MAX_ROWS      (MAX_ROWS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   csi_rpu_front #(
      .LINE_POS_W(LINE_POS_W),
      .ROW_W     (ROW_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_frame_begin(req_frame_begin),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   csi_rpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head      (q_head)
   );

   csi_rpu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_pixel_column(rsp_pixel_column),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_run_last    (rsp_run_last),
      .rsp_frame_last  (rsp_frame_last)
   );

   // Checks
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("group pushed into a full queue");

   a_frame_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> rsp_run_last)
      else $error("frame end flagged inside a group");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=>
         (rsp_valid && rsp_pixel_column == $past(rsp_pixel_column) + 13'd1 &&
          rsp_pixel_row == $past(rsp_pixel_row)))
      else $error("pixels of one group not delivered back to back");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import csi_rpu_pkg::*;

   localparam int STALL_LIMIT   = 2000;   // cycles with no item moving on either channel
   localparam int SETTLE_CYCLES = 16;     // pipeline plus group queue, with margin
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int RANDOM_BYTES  = 125;
   localparam int PHASE_CAP     = 48;
   localparam int PLAN_ROWS     = 39;

   typedef struct packed {
      logic [15:0] value;
      logic [12:0] column;
      logic [12:0] row;
      logic        run_last;
      logic        frame_last;
   } pixel_type;

   // Per-item tag: a pixel typed in by hand replaces the predicted one
   typedef struct packed {
      logic      known;
      pixel_type px;
   } typed_type;

   typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
      logic [7:0]             data;
      logic                   frame_start;
      logic                   known;
      pixel_type              px;
   } plan_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_data_byte;
   logic                   req_frame_begin;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [15:0]            rsp_pixel_value;
   logic [12:0]            rsp_pixel_column;
   logic [12:0]            rsp_pixel_row;
   logic                   rsp_run_last;
   logic                   rsp_frame_last;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   csi_raw_pixel_unpacker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_frame_begin  (req_frame_begin),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the registers, reset values
   logic [1:0]  cfg_fmt    = FMT_RAW8;
   logic [15:0] cfg_offset = 16'd0;
   logic [14:0] cfg_stride = 15'd1;
   logic [13:0] cfg_width  = 14'd1;
   logic [13:0] cfg_height = 14'd1;

   // Unpacker state as predicted
   int unsigned skip_cnt = 0;
   int unsigned line_pos = 0;
   int unsigned row_cnt  = 0;
   int unsigned col_cnt  = 0;
   int unsigned grp_idx  = 0;
   logic [7:0]  grp_bytes [4] = '{default: 8'h00};

   pixel_type    expected_pixels [$];
   typed_type    typed_pixels [$];
   plan_row_type directed_plan [PLAN_ROWS];

   int  fault_count  = 0;
   int  quiet_cycles = 0;
   int  burst_left   = 0;
   int  random_bytes = 0;
   bit  steady       = 1'b0;
   bit  hold_req     = 1'b0;
   int  hold_left    = 0;
   int  mode_left    = 0;
   int  rx_cycle     = 0;
   rx_mode_type rx_mode = RX_OPEN;

   // Unpack one byte; returns the number of pixels it completes
   function automatic int unpack_byte(input logic [7:0] b, input logic fs,
                                      output pixel_type res [4]);
      int unsigned stride, width, height, ppg, bpg, groups, pix_bytes, c;
      logic [15:0] v [4];
      bit          fl;
      int          n;
      n = 0;
      res = '{default: '0};
      if (fs) begin
         skip_cnt = 0;
         line_pos = 0;
         row_cnt  = 0;
         col_cnt  = 0;
         grp_idx  = 0;
      end
      if (skip_cnt < cfg_offset) begin
         skip_cnt++;
         return 0;
      end
      stride = (cfg_stride == 0) ? 1 : cfg_stride;
      if (stride > MAX_LINE_BYTES_DEF) stride = MAX_LINE_BYTES_DEF;
      width  = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      height = (cfg_height > MAX_ROWS_DEF) ? MAX_ROWS_DEF : cfg_height;
      if (row_cnt >= height) return 0;

      case (cfg_fmt)
         FMT_RAW8:  begin ppg = 1; bpg = 1; end
         FMT_RAW10: begin ppg = 4; bpg = 5; end
         FMT_RAW12: begin ppg = 2; bpg = 3; end
         default:   begin ppg = 0; bpg = 0; end
      endcase

      if (bpg != 0) begin
         groups = width / ppg;
         if (stride / bpg < groups) groups = stride / bpg;
         pix_bytes = groups * bpg;
         if (line_pos < pix_bytes) begin
            if (grp_idx + 1 < bpg) begin
               grp_bytes[grp_idx[1:0]] = b;
               grp_idx++;
            end else begin
               c  = col_cnt;
               fl = (row_cnt + 1 == height) && (c + ppg == groups * ppg);
               case (cfg_fmt)
                  FMT_RAW8: begin
                     v[0] = {b, 8'h00};
                  end
                  FMT_RAW10: begin
                     v[0] = {grp_bytes[0], b[1:0], 6'b0};
                     v[1] = {grp_bytes[1], b[3:2], 6'b0};
                     v[2] = {grp_bytes[2], b[5:4], 6'b0};
                     v[3] = {grp_bytes[3], b[7:6], 6'b0};
                  end
                  default: begin
                     v[0] = {grp_bytes[0], b[3:0], 4'b0};
                     v[1] = {grp_bytes[1], b[7:4], 4'b0};
                  end
               endcase
               for (int k = 0; k < int'(ppg); k++) begin
                  res[k].value      = v[k];
                  res[k].column     = 13'(c + k);
                  res[k].row        = 13'(row_cnt);
                  res[k].run_last   = (k + 1 == int'(ppg));
                  res[k].frame_last = (k + 1 == int'(ppg)) && fl;
               end
               n = ppg;
               col_cnt = c + ppg;
               grp_idx = 0;
            end
         end
      end

      line_pos++;
      if (line_pos >= stride) begin
         line_pos = 0;
         row_cnt++;
         col_cnt = 0;
         grp_idx = 0;
      end
      return n;
   endfunction

   // Directed table rows
   function automatic plan_row_type cfg_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] wdata);
      plan_row_type r;
      r = '0;
      r.kind  = ROW_CFG;
      r.index = idx;
      r.wdata = wdata;
      return r;
   endfunction

   function automatic plan_row_type byte_row(input logic [7:0] data, input logic fs);
      plan_row_type r;
      r = '0;
      r.kind        = ROW_BYTE;
      r.data        = data;
      r.frame_start = fs;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [7:0] data, input logic fs,
                                              input logic [15:0] value,
                                              input logic [12:0] col,
                                              input logic [12:0] row,
                                              input logic rl, input logic fl);
      plan_row_type r;
      r = byte_row(data, fs);
      r.known = 1'b1;
      r.px    = '{value: value, column: col, row: row, run_last: rl, frame_last: fl};
      return r;
   endfunction

   // Random size: mostly small, sometimes zero or beyond the saturation point
   function automatic logic [15:0] pick_size(input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'd0;
      if (r == 1) return 16'($urandom_range(8192, 65535));
      return 16'($urandom_range(1, hi));
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] wdata);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_PACK_FMT:     cfg_fmt    = wdata[1:0];
         REG_START_OFFSET: cfg_offset = wdata;
         REG_LINE_STRIDE:  cfg_stride = wdata[14:0];
         REG_FRAME_WIDTH:  cfg_width  = wdata[13:0];
         REG_FRAME_HEIGHT: cfg_height = wdata[13:0];
         default: ;
      endcase
   endtask

   // Offer one byte item; bursts of random length with random gaps between
   task automatic send_byte(input logic [7:0] data, input logic fs,
                            input logic known, input pixel_type px);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      typed_pixels.push_back('{known: known, px: px});
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_frame_begin <= fs;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering, wait for every expected pixel, then let the pipe empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input bit with_hold);
      logic [15:0] fmt_v, ofs_v, stride_v, width_v, height_v;
      int          pick, total;
      bit          full;
      wait_idle();
      if (with_hold) begin
         fmt_v    = 16'(FMT_RAW8);
         ofs_v    = 16'd0;
         stride_v = 16'd16;
         width_v  = 16'd16;
         height_v = 16'd3;
      end else begin
         fmt_v    = ($urandom_range(0, 9) == 0) ? 16'(FMT_RSVD) : 16'($urandom_range(0, 2));
         ofs_v    = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 20))
                                                : 16'($urandom_range(0, 3));
         stride_v = pick_size(16);
         width_v  = pick_size(16);
         height_v = pick_size(3);
      end
      // A partial phase changes one register and keeps the frame going
      full = with_hold || ($urandom_range(0, 6) != 0);
      pick = $urandom_range(0, 4);
      if (full || pick == 0) write_reg(REG_PACK_FMT, fmt_v);
      if (full || pick == 1) write_reg(REG_START_OFFSET, ofs_v);
      if (full || pick == 2) write_reg(REG_LINE_STRIDE, stride_v);
      if (full || pick == 3) write_reg(REG_FRAME_WIDTH, width_v);
      if (full || pick == 4) write_reg(REG_FRAME_HEIGHT, height_v);

      total = int'(cfg_offset) + (cfg_stride == 0 ? 1 : int'(cfg_stride)) *
              (cfg_height == 0 ? 1 : int'(cfg_height)) + $urandom_range(0, 4);
      if (total > PHASE_CAP) total = PHASE_CAP;
      steady = ($urandom_range(0, 3) == 0);
      if (with_hold) hold_req = 1'b1;
      for (int i = 0; i < total; i++)
         send_byte(8'($urandom_range(0, 255)),
                   (full && i == 0) || ($urandom_range(0, 39) == 0), 1'b0, '0);
      random_bytes += total;
   endtask

   // Receiver: own stall pattern, plus one long hold-off on request
   always @(posedge clock) begin : receiver
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 80);
         end
         mode_left--;
         case (rx_mode)
            RX_OPEN:    rsp_ready <= 1'b1;
            RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: rsp_ready <= (rx_cycle % 7) < 4;
            default:    rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
      rx_cycle++;
   end

   // Predict on each accepted byte, check each accepted pixel
   always @(posedge clock) begin : monitor
      typed_type tag;
      pixel_type made [4];
      pixel_type exp_px;
      pixel_type got_px;
      int        n;
      bit        moved;
      moved = 1'b0;
      if (!reset && req_valid && req_ready) begin
         moved = 1'b1;
         tag = typed_pixels.pop_front();
         n = unpack_byte(req_data_byte, req_frame_begin, made);
         if (tag.known) expected_pixels.push_back(tag.px);
         else for (int k = 0; k < n; k++) expected_pixels.push_back(made[k]);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         moved = 1'b1;
         got_px = '{value: rsp_pixel_value, column: rsp_pixel_column, row: rsp_pixel_row,
                    run_last: rsp_run_last, frame_last: rsp_frame_last};
         if (expected_pixels.size() == 0) begin
            report_fault($sformatf("unexpected pixel: v=%h c=%0d r=%0d rl=%b fl=%b",
                                   got_px.value, got_px.column, got_px.row,
                                   got_px.run_last, got_px.frame_last));
         end else begin
            exp_px = expected_pixels.pop_front();
            if (got_px.value !== exp_px.value || got_px.column !== exp_px.column ||
                got_px.row !== exp_px.row || got_px.run_last !== exp_px.run_last ||
                got_px.frame_last !== exp_px.frame_last)
               report_fault($sformatf(
                  "mismatch: exp v=%h c=%0d r=%0d rl=%b fl=%b got v=%h c=%0d r=%0d rl=%b fl=%b",
                  exp_px.value, exp_px.column, exp_px.row, exp_px.run_last, exp_px.frame_last,
                  got_px.value, got_px.column, got_px.row, got_px.run_last, got_px.frame_last));
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("** csi_raw_pixel_unpacker_core: FAILED **");
      $finish;
   end

   initial begin : main
      bit quiet;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_byte   <= 8'h00;
      req_frame_begin <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= REG_PACK_FMT;
      csr_wdata       <= '0;

      directed_plan = '{
         // defaults: RAW8, one pixel per frame
         known_row(8'hFF, 1'b1, 16'hFF00, 13'd0, 13'd0, 1'b1, 1'b1),
         byte_row(8'h00, 1'b0),                       // past the last row, dropped
         known_row(8'h00, 1'b1, 16'h0000, 13'd0, 13'd0, 1'b1, 1'b1),
         // RAW10 with one skipped byte and one pad byte
         cfg_row(REG_PACK_FMT, 16'(FMT_RAW10)),
         cfg_row(REG_START_OFFSET, 16'd1),
         cfg_row(REG_LINE_STRIDE, 16'd6),
         cfg_row(REG_FRAME_WIDTH, 16'd4),
         byte_row(8'h5A, 1'b1),
         byte_row(8'hFF, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'hFF, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'hE4, 1'b0),                       // each low-bit pair differs
         byte_row(8'h77, 1'b0),
         // RAW12, two rows
         cfg_row(REG_PACK_FMT, 16'(FMT_RAW12)),
         cfg_row(REG_START_OFFSET, 16'd0),
         cfg_row(REG_LINE_STRIDE, 16'd3),
         cfg_row(REG_FRAME_WIDTH, 16'd2),
         cfg_row(REG_FRAME_HEIGHT, 16'd2),
         byte_row(8'hAB, 1'b1), byte_row(8'hCD, 1'b0), byte_row(8'h5A, 1'b0),
         byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
         // reserved format drops everything
         cfg_row(REG_PACK_FMT, 16'(FMT_RSVD)),
         byte_row(8'h12, 1'b1), byte_row(8'h34, 1'b0),
         // zero stride, width beyond the limit, zero height
         cfg_row(REG_PACK_FMT, 16'(FMT_RAW8)),
         cfg_row(REG_LINE_STRIDE, 16'd0),
         cfg_row(REG_FRAME_WIDTH, 16'h3FFF),
         cfg_row(REG_FRAME_HEIGHT, 16'd0),
         byte_row(8'h80, 1'b1),
         // stride and height beyond their limits
         cfg_row(REG_FRAME_HEIGHT, 16'h3FFF),
         cfg_row(REG_LINE_STRIDE, 16'h7FFF),
         known_row(8'h80, 1'b1, 16'h8000, 13'd0, 13'd0, 1'b1, 1'b0),
         byte_row(8'h01, 1'b0),
         // zero width
         cfg_row(REG_FRAME_WIDTH, 16'd0),
         byte_row(8'h42, 1'b1)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      quiet = 1'b1;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CFG) begin
            if (!quiet) wait_idle();
            quiet = 1'b1;
            write_reg(directed_plan[i].index, directed_plan[i].wdata);
         end else begin
            quiet = 1'b0;
            send_byte(directed_plan[i].data, directed_plan[i].frame_start,
                      directed_plan[i].known, directed_plan[i].px);
         end
      end

      // Random frames; the first one runs into a long receiver hold-off
      random_phase(1'b1);
      while (random_bytes < RANDOM_BYTES) random_phase(1'b0);

      // Largest start offset: a short RAW8 frame is skipped entirely
      wait_idle();
      write_reg(REG_PACK_FMT, 16'(FMT_RAW8));
      write_reg(REG_START_OFFSET, 16'hFFFF);
      write_reg(REG_LINE_STRIDE, 16'd4);
      write_reg(REG_FRAME_WIDTH, 16'd4);
      write_reg(REG_FRAME_HEIGHT, 16'd1);
      steady = 1'b0;
      for (int i = 0; i < 8; i++)
         send_byte(8'($urandom_range(0, 255)), i == 0, 1'b0, '0);

      wait_idle();
      if (expected_pixels.size() != 0) begin
         fault_count += expected_pixels.size();
         $display("%0d expected pixels never arrived", expected_pixels.size());
      end
      if (fault_count == 0)
         $display("** csi_raw_pixel_unpacker_core: PASSED **");
      else
         $display("** csi_raw_pixel_unpacker_core: FAILED **");
      $finish;
   end

endmodule
